[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the partitioner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define GBMC_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error(msg);

// same-cycle implication
`define GBMC_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBMC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gbmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbmc_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gbmc_pkg;

  localparam int VW = 13;  // vertex field width
  localparam int WW = 32;  // edge weight width

  localparam logic [VW-1:0] VCOUNT_RST = 13'd2;

  // item kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_PLACE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status
  localparam logic [1:0] STAT_PLACED  = 2'd0;
  localparam logic [1:0] STAT_ALREADY = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  // per-vertex side table codes
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_0    = 2'd1;
  localparam logic [1:0] SIDE_1    = 2'd2;

  typedef struct packed {
    logic capture;      // latch item, read side of named vertex
    logic add_edge;     // store edge if valid and room
    logic clear_begin;  // zero edge count and side counts, restart sweep
    logic clear_step;   // write one side table entry to unplaced
    logic emit_oor;     // result: vertex out of range
    logic emit_placed;  // result: vertex already placed
    logic scan_begin;   // zero sums and scan pointer
    logic scan_issue;   // read next stored edge
    logic decide;       // choose side, update table and counts, result
  } gbmc_cmd_t;

  typedef struct packed {
    logic u_in_range;
    logic u_placed;
    logic edges_empty;
    logic scan_last;
    logic pipe_busy;
    logic clear_last;
  } gbmc_stat_t;

endpackage

[rtl/core/gbmc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbmc_ctrl
// Sequencer: clearing sweep, edge load, lookup, edge scan and side decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_kind,
  input  gbmc_pkg::gbmc_stat_t stat,
  output gbmc_pkg::gbmc_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (in_kind)
            gbmc_pkg::KIND_ADD: begin
              cmd.add_edge = 1'b1;
            end
            gbmc_pkg::KIND_CLEAR: begin
              cmd.clear_begin = 1'b1;
              state_nxt       = S_CLEAR;
            end
            gbmc_pkg::KIND_PLACE: begin
              if (stat.u_in_range) begin
                state_nxt = S_LOOK;
              end else begin
                cmd.emit_oor = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOOK: begin
        if (stat.u_placed) begin
          cmd.emit_placed = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_begin = 1'b1;
          state_nxt      = stat.edges_empty ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reset runs the side table clearing sweep first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `GBMC_ASSERT_ALWAYS(a_one_result, clk, rst_n,
    $onehot0({cmd.emit_oor, cmd.emit_placed, cmd.decide}),
    "gbmc_ctrl: more than one result source in a cycle")
  `GBMC_ASSERT_IMPL(a_scan_has_edges, clk, rst_n,
    state_r == S_SCAN, !stat.edges_empty,
    "gbmc_ctrl: scanning an empty edge store")

endmodule

[rtl/core/gbmc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbmc_datapath
// Edge store, side table, neighbor-sum pipeline, counts and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbmc_datapath #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gbmc_pkg::gbmc_cmd_t             cmd,
  output gbmc_pkg::gbmc_stat_t            stat,
  input  logic [gbmc_pkg::VW-1:0]         in_first_vertex,
  input  logic [gbmc_pkg::VW-1:0]         in_second_vertex,
  input  logic signed [gbmc_pkg::WW-1:0]  in_edge_weight,
  input  logic                            cfg_wr,
  input  logic [gbmc_pkg::VW-1:0]         cfg_vertex_count,
  output logic                            out_valid,
  output logic [gbmc_pkg::VW-1:0]         out_placed_vertex,
  output logic                            out_side,
  output logic [1:0]                      out_status
);

  localparam int VW   = gbmc_pkg::VW;
  localparam int WW   = gbmc_pkg::WW;
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int ACCW = WW + 1 + $clog2(MAX_EDGES);
  localparam int EDW  = 2 * VW + WW;

  // configuration
  logic [VW-1:0] vcount_r;
  logic [VW-1:0] eff_n;
  logic [VW-2:0] cap;

  // item and counters
  logic [VW-1:0]  u_r;
  logic [ECW-1:0] edge_total_r;
  logic [ECW-1:0] scan_idx_r;
  logic [VAW-1:0] clr_idx_r;
  logic [VCW-1:0] s0_cnt_r;
  logic [VCW-1:0] s1_cnt_r;

  // storage
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [1:0]     side_mem [MAX_VERTICES];
  logic [EDW-1:0] e_rd_r;
  logic [1:0]     side_rd_r;

  // scan pipeline
  logic                  p1_vld_r;
  logic                  p2_vld_r;
  logic signed [WW-1:0]  p2_w_r;
  logic signed [ACCW-1:0] s0_r;
  logic signed [ACCW-1:0] s1_r;

  logic                 u_ok;
  logic                 v_ok;
  logic                 edge_full;
  logic                 edge_we;
  logic [VW-1:0]        e_a;
  logic [VW-1:0]        e_b;
  logic signed [WW-1:0] e_w;
  logic                 hit_a;
  logic                 hit;
  logic [VW-1:0]        nb;
  logic [VW-1:0]        u_m1;
  logic [VW-1:0]        in_m1;
  logic [VW-1:0]        nb_m1;
  logic [VAW-1:0]       side_ra;
  logic                 side_we;
  logic [VAW-1:0]       side_wa;
  logic [1:0]           side_wd;
  logic                 to_side1;

  assign eff_n = (32'(vcount_r) > 32'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount_r;
  assign cap   = eff_n[VW-1:1];

  assign u_ok      = (in_first_vertex != '0) && (in_first_vertex <= eff_n);
  assign v_ok      = (in_second_vertex != '0) && (in_second_vertex <= eff_n);
  assign edge_full = (edge_total_r == ECW'(MAX_EDGES));
  assign edge_we   = cmd.add_edge && u_ok && v_ok && !edge_full;

  // stored edge: {a, b, weight}
  assign e_a   = e_rd_r[EDW-1 -: VW];
  assign e_b   = e_rd_r[WW +: VW];
  assign e_w   = e_rd_r[WW-1:0];
  assign hit_a = (e_a == u_r);
  assign hit   = hit_a || (e_b == u_r);
  // for a self loop the neighbor is the vertex itself, still unplaced
  assign nb    = hit_a ? e_b : e_a;

  // vertex v lives at table entry v-1
  assign u_m1  = u_r - VW'(1);
  assign in_m1 = in_first_vertex - VW'(1);
  assign nb_m1 = nb - VW'(1);

  assign side_ra = cmd.capture ? VAW'(in_m1) : VAW'(nb_m1);
  assign side_we = cmd.clear_step || cmd.decide;
  assign side_wa = cmd.clear_step ? clr_idx_r : VAW'(u_m1);
  assign side_wd = cmd.clear_step ? gbmc_pkg::SIDE_NONE
                 : (to_side1 ? gbmc_pkg::SIDE_1 : gbmc_pkg::SIDE_0);

  // tie goes to side 1; a full wanted side pushes to the other
  assign to_side1 = (s0_r >= s1_r) ? (32'(s1_cnt_r) < 32'(cap))
                                   : !(32'(s0_cnt_r) < 32'(cap));

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total_r[EAW-1:0]] <= {in_first_vertex, in_second_vertex, in_edge_weight};
    end
    e_rd_r <= edge_mem[scan_idx_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (side_we) begin
      side_mem[side_wa] <= side_wd;
    end
    side_rd_r <= side_mem[side_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= gbmc_pkg::VCOUNT_RST;
      edge_total_r <= '0;
      scan_idx_r   <= '0;
      clr_idx_r    <= '0;
      s0_cnt_r     <= '0;
      s1_cnt_r     <= '0;
      p1_vld_r     <= 1'b0;
      p2_vld_r     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        vcount_r <= cfg_vertex_count;
      end
      if (cmd.clear_begin) begin
        edge_total_r <= '0;
        s0_cnt_r     <= '0;
        s1_cnt_r     <= '0;
        clr_idx_r    <= '0;
      end else begin
        if (edge_we) begin
          edge_total_r <= edge_total_r + ECW'(1);
        end
        if (cmd.clear_step) begin
          clr_idx_r <= clr_idx_r + VAW'(1);
        end
        if (cmd.decide) begin
          if (to_side1) begin
            s1_cnt_r <= s1_cnt_r + VCW'(1);
          end else begin
            s0_cnt_r <= s0_cnt_r + VCW'(1);
          end
        end
      end
      if (cmd.scan_begin) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + ECW'(1);
      end
      p1_vld_r  <= cmd.scan_issue;
      p2_vld_r  <= p1_vld_r && hit;
      out_valid <= cmd.emit_oor || cmd.emit_placed || cmd.decide;
    end
  end

  always_ff @(posedge clk) begin
    p2_w_r <= e_w;
    if (cmd.capture) begin
      u_r <= in_first_vertex;
    end
    if (cmd.scan_begin) begin
      s0_r <= '0;
      s1_r <= '0;
    end else if (p2_vld_r) begin
      if (side_rd_r == gbmc_pkg::SIDE_0) begin
        s0_r <= s0_r + ACCW'(p2_w_r);
      end else if (side_rd_r == gbmc_pkg::SIDE_1) begin
        s1_r <= s1_r + ACCW'(p2_w_r);
      end
    end
    if (cmd.emit_oor) begin
      out_placed_vertex <= in_first_vertex;
      out_side          <= 1'b0;
      out_status        <= gbmc_pkg::STAT_RANGE;
    end else if (cmd.emit_placed) begin
      out_placed_vertex <= u_r;
      out_side          <= (side_rd_r == gbmc_pkg::SIDE_1);
      out_status        <= gbmc_pkg::STAT_ALREADY;
    end else if (cmd.decide) begin
      out_placed_vertex <= u_r;
      out_side          <= to_side1;
      out_status        <= gbmc_pkg::STAT_PLACED;
    end
  end

  assign stat.u_in_range  = u_ok;
  assign stat.u_placed    = (side_rd_r != gbmc_pkg::SIDE_NONE);
  assign stat.edges_empty = (edge_total_r == '0);
  assign stat.scan_last   = (scan_idx_r == edge_total_r - ECW'(1));
  assign stat.pipe_busy   = p1_vld_r || p2_vld_r;
  assign stat.clear_last  = (clr_idx_r == VAW'(MAX_VERTICES - 1));

  `GBMC_ASSERT_ALWAYS(a_edge_bound, clk, rst_n,
    32'(edge_total_r) <= 32'(MAX_EDGES),
    "gbmc_datapath: edge count beyond store depth")
  `GBMC_ASSERT_NEXT(a_one_placed, clk, rst_n, cmd.decide,
    32'(s0_cnt_r) + 32'(s1_cnt_r) == $past(32'(s0_cnt_r) + 32'(s1_cnt_r)) + 32'd1,
    "gbmc_datapath: decision did not add exactly one placement")
  `GBMC_ASSERT_IMPL(a_pipe_order, clk, rst_n, p2_vld_r, $past(p1_vld_r),
    "gbmc_datapath: sum stage valid without edge stage before it")

endmodule

[rtl/core/greedy_balanced_max_cut.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_balanced_max_cut
// Balanced greedy max-cut two-way partitioner, command-style interface.
// ----------------------------------------------------------------------------
// Add-edge items leave busy low; out-of-range place items strobe a result the next cycle.
// A new placement looks up the vertex, scans every stored edge, lets the sum pipeline drain
// and then decides, skipping the scan with an empty store; busy drops in the cycle of its result.
// An already-placed vertex returns its result from the lookup, without a scan.
// Reset and clear items run a sweep over all MAX_VERTICES side table entries, busy high.
// Results strobe out_valid for one cycle; the receiver cannot stall.
module greedy_balanced_max_cut #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [gbmc_pkg::VW-1:0]         in_first_vertex,
  input  logic [gbmc_pkg::VW-1:0]         in_second_vertex,
  input  logic signed [gbmc_pkg::WW-1:0]  in_edge_weight,
  output logic                            out_valid,
  output logic [gbmc_pkg::VW-1:0]         out_placed_vertex,
  output logic                            out_side,
  output logic [1:0]                      out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbmc_pkg::VW-1:0]         cfg_vertex_count
);

  gbmc_pkg::gbmc_cmd_t  cmd;
  gbmc_pkg::gbmc_stat_t stat;

  assign cfg_ready = 1'b1;

  gbmc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  gbmc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_first_vertex   (in_first_vertex),
    .in_second_vertex  (in_second_vertex),
    .in_edge_weight    (in_edge_weight),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_vertex_count  (cfg_vertex_count),
    .out_valid         (out_valid),
    .out_placed_vertex (out_placed_vertex),
    .out_side          (out_side),
    .out_status        (out_status)
  );

endmodule
